>>> rtl/clause_violation_counter_defines.svh
// Assertion macros for the checker file.
`ifndef CLAUSE_VIOLATION_COUNTER_DEFINES_SVH
`define CLAUSE_VIOLATION_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CVC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clause_violation_counter: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clause_violation_counter: assertion failed");

`endif

>>> rtl/cvc_pkg.sv
`timescale 1ns / 1ps
package cvc_pkg;

   localparam int MAX_VARIABLES = 4096;
   localparam int COUNT_WIDTH   = 16;
   localparam int ADDR_W        = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;

   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 12;
   localparam int VALUE_W  = 2;
   localparam int TOTAL_W  = 16;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EVAL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Pipeline control carried from the input stage to the evaluation stage.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              negated;
      logic              last_in_clause;
      logic              xor_clause;
      logic              in_range;
   } stage_ctl_type;

endpackage

>>> rtl/cvc_ram.sv
`timescale 1ns / 1ps
module cvc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/clause_violation_counter.sv
`timescale 1ns / 1ps
// Evaluates a stream of literals against a stored truth assignment and counts
// violated OR and odd-parity clauses. One transaction is taken every cycle
// that req_ready is high; a clause verdict is offered on the rsp channel
// once the clause's last literal has passed stage 1 and the result register:
// the assignment RAM is read at the accepting edge, and the literal
// evaluation and count update feed the result register. The req side stalls
// only while a clause end waits behind a result that rsp_ready holds. The
// assignment RAM is not cleared by reset: evaluating a variable that was
// never written gives an undefined verdict. Kind 2 transactions clear only
// the count; an open clause keeps its accumulated literals.
module clause_violation_counter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cvc_pkg::FUNC_W-1:0]      req_func,
   input  logic [cvc_pkg::INDEX_W-1:0]     req_var_index,
   input  logic signed [cvc_pkg::VALUE_W-1:0] req_value,
   input  logic                            req_negated,
   input  logic                            req_last_in_clause,
   input  logic                            req_xor_clause,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_clause_violated,
   output logic [cvc_pkg::TOTAL_W-1:0]     rsp_violated_total,
   output logic                            rsp_all_satisfied
);
   import cvc_pkg::*;

   logic                   req_fire;
   logic                   req_in_range;
   logic [ADDR_W-1:0]      addr;
   logic [VALUE_W-1:0]     ram_rd;

   logic                   s1_valid_ff, s1_valid_in;
   stage_ctl_type          s1_ctl_ff, s1_ctl_in;
   logic                   s1_has_rsp;
   logic                   s1_advance;

   logic                   any_true_ff, any_true_in;
   logic                   parity_ff, parity_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   out_violated_ff, out_violated_in;
   logic [TOTAL_W-1:0]     out_total_ff, out_total_in;
   logic                   out_all_sat_ff, out_all_sat_in;

   logic [VALUE_W-1:0]     var_value;
   logic                   lit_true;
   logic                   acc_any;
   logic                   acc_parity;
   logic                   violated;
   logic [COUNT_WIDTH-1:0] count_next;

   assign req_in_range = 32'(req_var_index) < 32'(MAX_VARIABLES);
   assign addr         = ADDR_W'(req_var_index);
   assign req_fire     = req_valid && req_ready;

   cvc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_VARIABLES)
   ) u_assign_ram (
      .clock   (clock),
      .wr_en   (req_fire && (req_func == FUNC_WRITE) && req_in_range),
      .wr_addr (addr),
      .wr_data (req_value),
      .rd_en   (req_fire),
      .rd_addr (addr),
      .rd_data (ram_rd)
   );

   // Stall stage 1 only when it holds a result and the output register is full and not taken.
   assign s1_has_rsp = (s1_ctl_ff.func == FUNC_EVAL) && s1_ctl_ff.last_in_clause;
   assign s1_advance = s1_valid_ff && (!s1_has_rsp || !out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ctl_in   = s1_ctl_ff;
      if (req_fire) begin
         s1_valid_in              = 1'b1;
         s1_ctl_in.func           = req_func;
         s1_ctl_in.negated        = req_negated;
         s1_ctl_in.last_in_clause = req_last_in_clause;
         s1_ctl_in.xor_clause     = req_xor_clause;
         s1_ctl_in.in_range       = req_in_range;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Literal evaluation; the value patterns with the sign bit set read as false.
   assign var_value  = s1_ctl_ff.in_range ? ram_rd : '0;
   assign lit_true   = s1_ctl_ff.negated ? var_value[VALUE_W-1]
                                         : (var_value == VALUE_W'(1));
   assign acc_any    = any_true_ff | lit_true;
   assign acc_parity = parity_ff ^ lit_true;
   assign violated   = s1_ctl_ff.xor_clause ? !acc_parity : !acc_any;
   assign count_next = (violated && (count_ff != COUNT_MAX)) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      any_true_in     = any_true_ff;
      parity_in       = parity_ff;
      count_in        = count_ff;
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_violated_in = out_violated_ff;
      out_total_in    = out_total_ff;
      out_all_sat_in  = out_all_sat_ff;
      if (s1_advance) begin
         case (s1_ctl_ff.func)
            FUNC_CLEAR: begin
               count_in = '0;
            end
            FUNC_EVAL: begin
               if (s1_ctl_ff.last_in_clause) begin
                  any_true_in     = 1'b0;
                  parity_in       = 1'b0;
                  count_in        = count_next;
                  out_valid_in    = 1'b1;
                  out_violated_in = violated;
                  out_total_in    = TOTAL_W'(count_next);
                  out_all_sat_in  = (count_next == '0);
               end else begin
                  any_true_in = acc_any;
                  parity_in   = acc_parity;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         any_true_ff  <= 1'b0;
         parity_ff    <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         any_true_ff  <= any_true_in;
         parity_ff    <= parity_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff       <= s1_ctl_in;
      out_violated_ff <= out_violated_in;
      out_total_ff    <= out_total_in;
      out_all_sat_ff  <= out_all_sat_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_clause_violated = out_violated_ff;
   assign rsp_violated_total  = out_total_ff;
   assign rsp_all_satisfied   = out_all_sat_ff;

endmodule

>>> rtl/cvc_checker.sv
`timescale 1ns / 1ps
`include "clause_violation_counter_defines.svh"
module cvc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_clause_violated,
   input logic [cvc_pkg::TOTAL_W-1:0] rsp_violated_total,
   input logic                        rsp_all_satisfied
);
   import cvc_pkg::*;

   // A stalled transaction stays offered.
   `CVC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Nothing is offered and the input is open in the cycle after reset.
   `CVC_ASSERT_IMPLY(a_idle_after_reset, clock, reset, $past(reset), !rsp_valid && req_ready)

   // The flag tracks the shown total.
   `CVC_ASSERT_IMPLY(a_all_sat_match, clock, reset, rsp_valid,
      rsp_all_satisfied == (rsp_violated_total == '0))

   // A violated clause always lifts the total above zero.
   `CVC_ASSERT_IMPLY(a_violated_counts, clock, reset, rsp_valid && rsp_clause_violated,
      !rsp_all_satisfied && (rsp_violated_total != '0))

endmodule

bind clause_violation_counter cvc_checker u_cvc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_clause_violated (rsp_clause_violated),
   .rsp_violated_total  (rsp_violated_total),
   .rsp_all_satisfied   (rsp_all_satisfied)
);

>>> sim/clause_violation_counter_tb.sv
`timescale 1ns / 1ps
module clause_violation_counter_tb;
   import cvc_pkg::*;

   localparam logic [FUNC_W-1:0]  FUNC_UNUSED   = 2'd3;
   localparam logic [VALUE_W-1:0] VAL_NONE      = 2'b00;
   localparam logic [VALUE_W-1:0] VAL_TRUE      = 2'b01;
   localparam logic [VALUE_W-1:0] VAL_MINUS_TWO = 2'b10;
   localparam logic [VALUE_W-1:0] VAL_FALSE     = 2'b11;
   localparam int RANDOM_ITEMS    = 1950;
   localparam int IDLE_PCT        = 33;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] idx;
      logic [VALUE_W-1:0] val;
      logic               neg;
      logic               last;
      logic               par;
   } literal_item_type;

   typedef struct {
      logic               violated;
      logic [TOTAL_W-1:0] total;
      logic               all_sat;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [FUNC_W-1:0] req_func = '0;
   logic [INDEX_W-1:0] req_var_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic req_negated = 1'b0;
   logic req_last_in_clause = 1'b0;
   logic req_xor_clause = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_clause_violated;
   logic [TOTAL_W-1:0] rsp_violated_total;
   logic rsp_all_satisfied;

   clause_violation_counter DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_var_index(req_var_index),
      .req_value(req_value),
      .req_negated(req_negated),
      .req_last_in_clause(req_last_in_clause),
      .req_xor_clause(req_xor_clause),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_clause_violated(rsp_clause_violated),
      .rsp_violated_total(rsp_violated_total),
      .rsp_all_satisfied(rsp_all_satisfied)
   );

   always #2 clock = ~clock;

   literal_item_type pending_items[$];
   verdict_type      expected_verdicts[$];
   literal_item_type accepted_item;
   literal_item_type next_item;
   verdict_type      oldest_verdict;

   // predictor state
   logic [VALUE_W-1:0] assignment_copy[MAX_VARIABLES];
   logic               open_any_true = 1'b0;
   logic               open_parity   = 1'b0;
   logic [COUNT_WIDTH-1:0] violation_tally = '0;

   // generator bookkeeping: only variables already written are ever read
   bit gen_written[MAX_VARIABLES];
   int written_vars[$];
   int gen_count;

   int items_sent = 0;
   int verdicts_seen = 0;
   int mismatch_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic [VALUE_W-1:0] rand_val();
      return VALUE_W'($urandom_range(3));
   endfunction

   task automatic fold_literal(input literal_item_type t);
      logic [VALUE_W-1:0] v;
      logic lit_true;
      logic violated;
      verdict_type vd;
      case (t.func)
         FUNC_WRITE: assignment_copy[t.idx] = t.val;
         FUNC_CLEAR: violation_tally = '0;
         FUNC_EVAL: begin
            v = assignment_copy[t.idx];
            // negative patterns (sign bit set) count as false
            lit_true = t.neg ? v[1] : (v == VAL_TRUE);
            if (lit_true) begin
               open_any_true = 1'b1;
               open_parity   = ~open_parity;
            end
            if (t.last) begin
               violated = t.par ? !open_parity : !open_any_true;
               if (violated && violation_tally != COUNT_MAX)
                  violation_tally = violation_tally + 1'b1;
               open_any_true = 1'b0;
               open_parity   = 1'b0;
               vd.violated = violated;
               vd.total    = violation_tally[TOTAL_W-1:0];
               vd.all_sat  = (violation_tally == 0);
               expected_verdicts = {expected_verdicts, vd};
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_item(input logic [FUNC_W-1:0] f, input int idx,
                             input logic [VALUE_W-1:0] v, input logic n,
                             input logic l, input logic p);
      literal_item_type t;
      t.func = f;
      t.idx  = INDEX_W'(idx);
      t.val  = v;
      t.neg  = n;
      t.last = l;
      t.par  = p;
      if (f == FUNC_WRITE && !gen_written[idx]) begin
         gen_written[idx] = 1'b1;
         written_vars = {written_vars, idx};
      end
      pending_items = {pending_items, t};
      gen_count++;
   endtask

   function automatic int pick_written();
      return written_vars[$urandom_range(written_vars.size() - 1)];
   endfunction

   task automatic queue_random_write();
      int idx;
      idx = ($urandom_range(1) == 0) ? pick_written() : $urandom_range(MAX_VARIABLES - 1);
      queue_item(FUNC_WRITE, idx, rand_val(), rand_bit(), rand_bit(), rand_bit());
   endtask

   // well-formed clause with random literals; optionally break it with
   // writes or clears between its literals
   task automatic queue_random_clause(input bit broken);
      int len;
      logic par;
      len = $urandom_range(1, 6);
      par = rand_bit();
      for (int k = 0; k < len; k++) begin
         if (broken && $urandom_range(2) == 0) begin
            if ($urandom_range(1) == 0)
               queue_random_write();
            else
               queue_item(FUNC_CLEAR, $urandom_range(MAX_VARIABLES - 1), rand_val(),
                          rand_bit(), rand_bit(), rand_bit());
         end
         queue_item(FUNC_EVAL, pick_written(), rand_val(), rand_bit(),
                    k == len - 1, (k == len - 1) ? par : rand_bit());
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accepted_item.func = req_func;
            accepted_item.idx  = req_var_index;
            accepted_item.val  = req_value;
            accepted_item.neg  = req_negated;
            accepted_item.last = req_last_in_clause;
            accepted_item.par  = req_xor_clause;
            fold_literal(accepted_item);
            items_sent++;
         end
         if (!req_valid || req_ready) begin
            // no idling for a stretch of the random part
            if (pending_items.size() != 0 &&
                ((items_sent >= 800 && items_sent < 1200) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               next_item = pending_items.pop_front();
               req_func           <= next_item.func;
               req_var_index      <= next_item.idx;
               req_value          <= next_item.val;
               req_negated        <= next_item.neg;
               req_last_in_clause <= next_item.last;
               req_xor_clause     <= next_item.par;
               req_valid          <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected transaction, violated_total",
                               longint'(rsp_violated_total), 0);
            end else begin
               oldest_verdict = expected_verdicts.pop_front();
               if (rsp_clause_violated !== oldest_verdict.violated)
                  report_mismatch("clause_violated", longint'(rsp_clause_violated),
                                  longint'(oldest_verdict.violated));
               if (rsp_violated_total !== oldest_verdict.total)
                  report_mismatch("violated_total", longint'(rsp_violated_total),
                                  longint'(oldest_verdict.total));
               if (rsp_all_satisfied !== oldest_verdict.all_sat)
                  report_mismatch("all_satisfied", longint'(rsp_all_satisfied),
                                  longint'(oldest_verdict.all_sat));
            end
         end
         rsp_ready <= (verdicts_seen >= 200 && verdicts_seen < 500) ||
                      ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int r;
      // directed: extremes, every operation, special cases
      queue_item(FUNC_WRITE, 0, VAL_TRUE, 1'b0, 1'b0, 1'b0);
      queue_item(FUNC_WRITE, MAX_VARIABLES - 1, VAL_FALSE, 1'b1, 1'b1, 1'b1);
      queue_item(FUNC_WRITE, 1, VAL_NONE, 1'b0, 1'b0, 1'b0);
      queue_item(FUNC_WRITE, 2, VAL_MINUS_TWO, 1'b0, 1'b0, 1'b0);
      queue_item(FUNC_WRITE, 12'hAAA, VAL_TRUE, 1'b0, 1'b0, 1'b0);
      queue_item(FUNC_WRITE, 12'h555, VAL_FALSE, 1'b0, 1'b0, 1'b0);
      // unused code with clause-end set: no transaction out
      queue_item(FUNC_UNUSED, 0, VAL_FALSE, 1'b1, 1'b1, 1'b0);
      queue_item(FUNC_EVAL, 0, VAL_NONE, 1'b0, 1'b1, 1'b0);
      queue_item(FUNC_EVAL, 0, VAL_NONE, 1'b1, 1'b1, 1'b0);
      queue_item(FUNC_EVAL, MAX_VARIABLES - 1, VAL_NONE, 1'b1, 1'b1, 1'b0);
      queue_item(FUNC_EVAL, 1, VAL_NONE, 1'b0, 1'b0, 1'b0);
      queue_item(FUNC_EVAL, 1, VAL_NONE, 1'b1, 1'b1, 1'b0);
      queue_item(FUNC_EVAL, 2, VAL_NONE, 1'b1, 1'b1, 1'b0);
      queue_item(FUNC_EVAL, 2, VAL_NONE, 1'b0, 1'b1, 1'b0);
      // parity clauses: two true literals, then one
      queue_item(FUNC_EVAL, 0, VAL_NONE, 1'b0, 1'b0, 1'b1);
      queue_item(FUNC_EVAL, MAX_VARIABLES - 1, VAL_NONE, 1'b1, 1'b1, 1'b1);
      queue_item(FUNC_EVAL, 12'hAAA, VAL_NONE, 1'b0, 1'b0, 1'b1);
      queue_item(FUNC_EVAL, 1, VAL_NONE, 1'b0, 1'b1, 1'b1);
      // clause kind comes from the last literal
      queue_item(FUNC_EVAL, 0, VAL_NONE, 1'b0, 1'b0, 1'b0);
      queue_item(FUNC_EVAL, 12'hAAA, VAL_NONE, 1'b0, 1'b1, 1'b1);
      // clear inside an open clause keeps its literals
      queue_item(FUNC_EVAL, 0, VAL_NONE, 1'b0, 1'b0, 1'b0);
      queue_item(FUNC_CLEAR, 0, VAL_NONE, 1'b0, 1'b0, 1'b0);
      queue_item(FUNC_EVAL, 1, VAL_NONE, 1'b0, 1'b1, 1'b0);
      queue_item(FUNC_EVAL, 1, VAL_NONE, 1'b0, 1'b1, 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // hold the sender until the directed part has fully drained
      wait_drained();

      gen_count = 0;
      while (gen_count < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 60)
            queue_random_clause(1'b0);
         else if (r < 72)
            queue_random_clause(1'b1);
         else if (r < 88)
            queue_random_write();
         else if (r < 95)
            queue_item(FUNC_CLEAR, $urandom_range(MAX_VARIABLES - 1), rand_val(),
                       rand_bit(), rand_bit(), rand_bit());
         else
            queue_item(FUNC_UNUSED, $urandom_range(MAX_VARIABLES - 1), rand_val(),
                       rand_bit(), rand_bit(), rand_bit());
      end
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
